@@ hw/rtl/rrs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants of the round-robin sleep scheduler: operation
// and status codes, field widths and the ready queue control structs.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int ID_W   = 5;
	localparam int TICK_W = 32;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_SCHED = 2'd1,
		OP_TICK  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} st_t;

	// commands into the ready queue for one cycle
	typedef struct packed {
		logic            push;
		logic [ID_W-1:0] push_id;
		logic            rd_head;
		logic            pop;
	} rq_cmd_t;

	// ready queue status seen by the controller
	typedef struct packed {
		logic            full;
		logic            empty;
		logic [ID_W-1:0] head_id;
	} rq_stat_t;

endpackage

@@ hw/rtl/round_robin_sleep_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// round_robin_sleep_scheduler_core
// Task scheduler with a FIFO ready queue and an ordered sleep list, both
// held in RAM; id 0 is the idle task.
// ----------------------------------------------------------------------------
// usage
//   input channel: one transfer per command (operation, task_id,
//   goes_to_sleep, wake_tick, current_tick), qualified by in_valid/in_stall
//   output channel: exactly one result transfer per command (next_task,
//   switched, task_woken, status), qualified by out_valid/out_stall
//   steps, command transfer to result valid:
//     add, no-op                  straight to the finish state
//     schedule, queue empty       straight to the finish state
//     schedule, queue not empty   ready RAM read of the head first
//     tick check                  scan of the N sleepers listed; the
//                                 sleep RAM is scanned one entry per cycle
//   one command at a time: in_stall stays high from the transfer until the
//   result sits in the output register, so a tick check holds the input
//   while the whole sleep list is scanned
//   the next command is taken while a result still waits in the output
//   register; a stalled result holds there and the block waits before
//   writing the one after it
//   reset: ready queue and sleep list empty, idle task running, woken flag
//   clear; RAM contents are not cleared, no entry is read before written
// ----------------------------------------------------------------------------
module round_robin_sleep_scheduler_core #(
	parameter int MAX_TASKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [4:0]  task_id,
	input  logic        goes_to_sleep,
	input  logic [31:0] wake_tick,
	input  logic [31:0] current_tick,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  next_task,
	output logic        switched,
	output logic        task_woken,
	output logic [1:0]  status
);

	localparam int PTR_W  = $clog2(MAX_TASKS);
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int SL_W   = rrs_pkg::ID_W + rrs_pkg::TICK_W;
	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_TASKS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCHED,
		S_SCAN,
		S_FIN
	} state_t;

	state_t state_q;

	// scheduler state in flops
	logic [rrs_pkg::ID_W-1:0]  running_q;
	logic                      woken_q;
	logic [CNT_W-1:0]          sleep_count_q;

	// per-command working registers
	rrs_pkg::st_t              status_q;
	logic                      switched_q;
	logic [rrs_pkg::ID_W-1:0]  prev_q;
	logic [rrs_pkg::TICK_W-1:0] now_q;
	logic [PTR_W-1:0]          rd_idx_q;
	logic [CNT_W-1:0]          keep_q;

	// output register
	logic                      out_valid_q;
	logic [rrs_pkg::ID_W-1:0]  out_task_q;
	logic                      out_switched_q;
	logic                      out_woken_q;
	logic [1:0]                out_status_q;

	rrs_pkg::rq_cmd_t          rq_cmd;
	rrs_pkg::rq_stat_t         rq_stat;

	// sleep RAM ports, entry = {id, wake tick}
	logic                      sl_we;
	logic [PTR_W-1:0]          sl_waddr;
	logic [SL_W-1:0]           sl_wdata;
	logic                      sl_re;
	logic [PTR_W-1:0]          sl_raddr;
	logic [SL_W-1:0]           sl_rdata;

	logic                      in_fire;
	rrs_pkg::op_t              op;
	logic                      id_ok;
	logic                      sleep_full;
	logic                      sl_due;
	logic                      scan_last;
	logic [rrs_pkg::ID_W-1:0]  sl_id;
	logic [rrs_pkg::TICK_W-1:0] sl_tick;
	logic                      out_free;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign op       = rrs_pkg::op_t'(operation);
	assign id_ok    = (task_id != '0) && (32'(task_id) <= MAX_TASKS);
	assign sleep_full = (sleep_count_q == MAX_C);

	assign sl_id     = sl_rdata[SL_W-1 -: rrs_pkg::ID_W];
	assign sl_tick   = sl_rdata[rrs_pkg::TICK_W-1:0];
	assign sl_due    = (now_q >= sl_tick);
	assign scan_last = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == sleep_count_q);
	assign out_free  = !out_valid_q || !out_stall;

	rrs_ready_queue #(
		.MAX_TASKS (MAX_TASKS)
	) u_ready (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rq_cmd),
		.stat   (rq_stat)
	);

	rrs_ram #(
		.WIDTH (SL_W),
		.DEPTH (MAX_TASKS)
	) u_sleep_ram (
		.clk   (clk),
		.we    (sl_we),
		.waddr (sl_waddr),
		.wdata (sl_wdata),
		.re    (sl_re),
		.raddr (sl_raddr),
		.rdata (sl_rdata)
	);

	// RAM and queue commands
	always_comb begin
		rq_cmd   = '0;
		sl_we    = 1'b0;
		sl_waddr = '0;
		sl_wdata = '0;
		sl_re    = 1'b0;
		sl_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (op)
						rrs_pkg::OP_ADD: begin
							if (id_ok && !rq_stat.full) begin
								rq_cmd.push    = 1'b1;
								rq_cmd.push_id = task_id;
							end
						end
						rrs_pkg::OP_SCHED: begin
							// park the running task, never idle
							if (running_q != '0) begin
								if (goes_to_sleep) begin
									if (!sleep_full) begin
										sl_we    = 1'b1;
										sl_waddr = sleep_count_q[PTR_W-1:0];
										sl_wdata = {running_q, wake_tick};
									end
								end else if (!rq_stat.full) begin
									rq_cmd.push    = 1'b1;
									rq_cmd.push_id = running_q;
								end
							end
							// empty queue: a task parked now is its own head
							if (rq_stat.empty) begin
								rq_cmd.pop = rq_cmd.push;
							end else begin
								rq_cmd.rd_head = 1'b1;
							end
						end
						rrs_pkg::OP_TICK: begin
							if (sleep_count_q != '0) begin
								sl_re    = 1'b1;
								sl_raddr = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCHED: begin
				rq_cmd.pop = 1'b1;
			end
			S_SCAN: begin
				// due sleepers move to ready while it has room, the rest compact down to keep
				if (sl_due && !rq_stat.full) begin
					rq_cmd.push    = 1'b1;
					rq_cmd.push_id = sl_id;
				end else begin
					sl_we    = 1'b1;
					sl_waddr = keep_q[PTR_W-1:0];
					sl_wdata = sl_rdata;
				end
				if (!scan_last) begin
					sl_re    = 1'b1;
					sl_raddr = rd_idx_q + PTR_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			running_q      <= '0;
			woken_q        <= 1'b0;
			sleep_count_q  <= '0;
			status_q       <= rrs_pkg::ST_OK;
			switched_q     <= 1'b0;
			prev_q         <= '0;
			now_q          <= '0;
			rd_idx_q       <= '0;
			keep_q         <= '0;
			out_valid_q    <= 1'b0;
			out_task_q     <= '0;
			out_switched_q <= 1'b0;
			out_woken_q    <= 1'b0;
			out_status_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						status_q   <= rrs_pkg::ST_OK;
						switched_q <= 1'b0;
						state_q    <= S_FIN;
						case (op)
							rrs_pkg::OP_ADD: begin
								if (!id_ok) begin
									status_q <= rrs_pkg::ST_INVALID;
								end else if (rq_stat.full) begin
									status_q <= rrs_pkg::ST_FULL;
								end
							end
							rrs_pkg::OP_SCHED: begin
								prev_q <= running_q;
								if (running_q != '0) begin
									if (goes_to_sleep) begin
										if (sleep_full) begin
											status_q <= rrs_pkg::ST_FULL;
										end else begin
											sleep_count_q <= sleep_count_q + CNT_W'(1);
										end
									end else if (rq_stat.full) begin
										status_q <= rrs_pkg::ST_FULL;
									end
								end
								if (rq_stat.empty) begin
									if (rq_cmd.pop) begin
										// running task goes round and comes straight back
										woken_q <= 1'b0;
									end else begin
										running_q  <= '0;
										switched_q <= (running_q != '0);
									end
								end else begin
									state_q <= S_SCHED;
								end
							end
							rrs_pkg::OP_TICK: begin
								now_q    <= current_tick;
								rd_idx_q <= '0;
								keep_q   <= '0;
								if (sleep_count_q != '0) begin
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCHED: begin
					running_q  <= rq_stat.head_id;
					woken_q    <= 1'b0;
					switched_q <= (rq_stat.head_id != prev_q);
					state_q    <= S_FIN;
				end
				S_SCAN: begin
					if (sl_due && !rq_stat.full) begin
						woken_q <= 1'b1;
					end else begin
						if (sl_due) begin
							status_q <= rrs_pkg::ST_FULL;
						end
						keep_q <= keep_q + CNT_W'(1);
					end
					if (scan_last) begin
						sleep_count_q <= (sl_due && !rq_stat.full) ? keep_q
							: keep_q + CNT_W'(1);
						state_q <= S_FIN;
					end else begin
						rd_idx_q <= rd_idx_q + PTR_W'(1);
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_task_q     <= running_q;
						out_switched_q <= switched_q;
						out_woken_q    <= woken_q;
						out_status_q   <= status_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign next_task  = out_task_q;
	assign switched   = out_switched_q;
	assign task_woken = out_woken_q;
	assign status     = out_status_q;

	// no push into a full ready queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cmd.push |-> !rq_stat.full)
		else $error("ready queue push while full");

	// head read only with something queued, and its data is taken next cycle
	a_head_read: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cmd.rd_head |-> !rq_stat.empty ##1 (state_q == S_SCHED && rq_cmd.pop))
		else $error("ready head read not followed by pop");

	// sleep list never overflows
	a_sleep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sleep_count_q <= MAX_C)
		else $error("sleep count above depth");

	// compaction never writes ahead of the entry being read
	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (keep_q <= CNT_W'(rd_idx_q)))
		else $error("sleep compaction overtook scan");

	// a result is only written into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && out_stall) |=> (state_q == S_FIN && out_valid_q))
		else $error("result written over a stalled one");

endmodule

@@ hw/rtl/rrs_ram.sv @@
// ----------------------------------------------------------------------------
// rrs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/rrs_ready_queue.sv @@
// ----------------------------------------------------------------------------
// rrs_ready_queue
// Circular FIFO of runnable task ids kept in a RAM, with head pointer and
// fill count in flops. Push and pop may occur in the same cycle.
// ----------------------------------------------------------------------------
module rrs_ready_queue #(
	parameter int MAX_TASKS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rrs_pkg::rq_cmd_t   cmd,
	output rrs_pkg::rq_stat_t  stat
);

	localparam int PTR_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam logic [PTR_W:0]   MAX_P   = (PTR_W + 1)'(MAX_TASKS);
	localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_TASKS);
	localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(MAX_TASKS - 1);

	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W:0]   tail_sum;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] head_inc;
	logic [rrs_pkg::ID_W-1:0] head_rdata;

	// head + count stays below twice the depth, one subtract wraps it
	always_comb begin
		tail_sum = {1'b0, head_q} + (PTR_W + 1)'(count_q);
		if (tail_sum >= MAX_P) begin
			tail_sum = tail_sum - MAX_P;
		end
		tail     = tail_sum[PTR_W-1:0];
		head_inc = (head_q == LAST_P) ? '0 : head_q + PTR_W'(1);
	end

	rrs_ram #(
		.WIDTH (rrs_pkg::ID_W),
		.DEPTH (MAX_TASKS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (tail),
		.wdata (cmd.push_id),
		.re    (cmd.rd_head),
		.raddr (head_q),
		.rdata (head_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.pop) begin
				head_q <= head_inc;
			end
			case ({cmd.push, cmd.pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign stat.full    = (count_q == MAX_C);
	assign stat.empty   = (count_q == '0);
	assign stat.head_id = head_rdata;

endmodule
